>>> rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sigmoid table interpolator
// Holds the sample table image, built at elaboration, and the stage structs.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_W      = 10;
  localparam int IN_W        = 22;
  localparam int OUT_W       = 17;
  localparam int ROM_W       = 17;
  localparam int ROM_DEPTH   = TABLE_DEPTH + 1;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int IDX_W       = ROM_AW;
  localparam int POS_W       = IDX_W + FRAC_W;
  localparam int MAG_W       = IN_W - 1;

  localparam logic signed [IN_W-1:0] LIMIT_HI = 22'sd1310720;
  localparam logic signed [IN_W-1:0] LIMIT_LO = -22'sd1310720;
  localparam logic [OUT_W-1:0]       ONE_Q16  = 17'd65536;
  localparam logic [ROM_AW-1:0]      LAST_IDX = ROM_AW'(TABLE_DEPTH);

  // pos = floor(mag * TABLE_DEPTH / SCALE_DIV) via reciprocal multiply
  localparam int          SCALE_DIV   = 1280;
  localparam int          SCALE_SHIFT = 32;
  localparam logic [63:0] SCALE_MUL   =
    ((64'(TABLE_DEPTH) << SCALE_SHIFT) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV);
  localparam int          SCALE_W     = $clog2(SCALE_MUL + 64'd1);
  localparam int          PROD_W      = MAG_W + SCALE_W;

  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

  typedef logic [ROM_DEPTH*ROM_W-1:0] rom_img_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              sat_lo;
    logic              sat_hi;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] fr;
  } scale_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              sat_lo;
    logic              sat_hi;
    logic [FRAC_W-1:0] fr;
  } interp_ctl_t;

  // unsigned 64-bit quotient by shift and subtract
  function automatic logic [63:0] long_quot(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] quot;
    logic [64:0] rem;
    quot = '0;
    rem  = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem     = rem - {1'b0, dvs};
        quot[b] = 1'b1;
      end
    end
    return quot;
  endfunction

  // sigmoid samples over [0,20], exp(-x) from a series in Q0.31
  function automatic rom_img_t build_rom_img();
    rom_img_t    img;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] y;
    longint      acc;
    logic        done;
    img = '0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      f    = long_quot(64'(i) * 64'd20 * (64'd1 << 26), 64'(TABLE_DEPTH));
      acc  = longint'(ONE_Q31);
      term = ONE_Q31;
      done = 1'b0;
      for (int k = 1; k <= 40; k++) begin
        if (!done) begin
          term = (term * f) >> 31;
          term = long_quot(term, 64'(k));
          if (term == 64'd0) begin
            done = 1'b1;
          end else if (k[0]) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q31)) acc = longint'(ONE_Q31);
      e = 64'(acc);
      for (int s = 0; s < 5; s++) begin
        e = (e * e) >> 31;
      end
      den = ONE_Q31 + e;
      y   = long_quot((64'd1 << 47) + (den >> 1), den);
      img[i*ROM_W +: ROM_W] = y[ROM_W-1:0];
    end
    return img;
  endfunction

  localparam rom_img_t SAMPLE_IMG = build_rom_img();

endpackage

>>> rtl/sti_ram.sv
// ----------------------------------------------------------------------------
// sti_ram: generic memory
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sti_ram #(
  parameter int  WIDTH = 17,
  parameter int  DEPTH = 1025,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> rtl/sti_scale.sv
// ----------------------------------------------------------------------------
// sti_scale: input register and magnitude scaling
// Flags out-of-range samples and turns |x| into table index and fraction.
// ----------------------------------------------------------------------------
module sti_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [sti_pkg::IN_W-1:0]  sample,
  output sti_pkg::scale_t                  scl_out
);

  import sti_pkg::*;

  logic                    in_vld_r;
  logic signed [IN_W-1:0]  smp_r;
  logic                    neg;
  logic [IN_W-1:0]         abs_val;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [POS_W-1:0]        pos;
  scale_t                  scl_nxt;
  scale_t                  scl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= sample;
  end

  always_comb begin
    neg     = smp_r[IN_W-1];
    abs_val = neg ? (~smp_r + 1'b1) : smp_r;
    mag     = abs_val[MAG_W-1:0];
    prod    = PROD_W'(mag) * PROD_W'(SCALE_MUL);
    pos     = prod[SCALE_SHIFT +: POS_W];

    scl_nxt.valid  = in_vld_r;
    scl_nxt.neg    = neg;
    scl_nxt.sat_lo = smp_r < LIMIT_LO;
    scl_nxt.sat_hi = smp_r > LIMIT_HI;
    scl_nxt.idx    = pos[POS_W-1 -: IDX_W];
    scl_nxt.fr     = pos[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r <= '0;
    end else begin
      scl_r <= scl_nxt;
    end
  end

  assign scl_out = scl_r;

endmodule

>>> rtl/sti_interp.sv
// ----------------------------------------------------------------------------
// sti_interp: linear interpolation, saturation and mirroring
// Blends two neighboring samples, then applies range and sign handling.
// ----------------------------------------------------------------------------
module sti_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sti_pkg::interp_ctl_t        ctl_in,
  input  logic [sti_pkg::ROM_W-1:0]   r0,
  input  logic [sti_pkg::ROM_W-1:0]   r1,
  output logic                        out_valid,
  output logic [sti_pkg::OUT_W-1:0]   out_value
);

  import sti_pkg::*;

  localparam int DIFF_W  = ROM_W + 1;
  localparam int FRS_W   = FRAC_W + 1;
  localparam int IPROD_W = DIFF_W + FRS_W;
  localparam int SUM_W   = ROM_W + 2;

  interp_ctl_t                ctl_a_r;
  interp_ctl_t                ctl_b_r;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [IPROD_W-1:0]  prod_nxt;
  logic signed [IPROD_W-1:0]  prod_r;
  logic [ROM_W-1:0]           base_r;
  logic signed [IPROD_W-1:0]  shifted;
  logic signed [SUM_W-1:0]    sum;
  logic [OUT_W-1:0]           y;
  logic [OUT_W-1:0]           res_nxt;
  logic [OUT_W-1:0]           res_r;
  logic                       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      ctl_a_r <= ctl_in;
      ctl_b_r <= ctl_a_r;
      vld_r   <= ctl_b_r.valid;
    end
  end

  // r0*(1024-fr) + r1*fr, folded into r0*1024 + (r1-r0)*fr
  always_comb begin
    diff     = $signed({1'b0, r1}) - $signed({1'b0, r0});
    prod_nxt = diff * $signed({1'b0, ctl_a_r.fr});
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    base_r <= r0;
  end

  always_comb begin
    shifted = prod_r >>> FRAC_W;
    sum     = $signed({2'b00, base_r}) + $signed(shifted[SUM_W-1:0]);
    if (sum > $signed({2'b00, ONE_Q16})) begin
      y = ONE_Q16;
    end else if (sum < 0) begin
      y = '0;
    end else begin
      y = sum[OUT_W-1:0];
    end

    if (ctl_b_r.sat_lo) begin
      res_nxt = '0;
    end else if (ctl_b_r.sat_hi) begin
      res_nxt = ONE_Q16;
    end else if (ctl_b_r.neg) begin
      res_nxt = ONE_Q16 - y;
    end else begin
      res_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_value = res_r;

endmodule

>>> rtl/sigmoid_table_interpolator.sv
// ----------------------------------------------------------------------------
// sigmoid_table_interpolator: sigmoid of a Q5.16 sample as a Q1.16 value
// Valid path: in_vld_r, scl_r, ctl_a_r, ctl_b_r, vld_r, then out_valid.
// Throughput: one transaction per cycle while busy is low; the output strobe
// cannot be stalled. Reset: the sample memory is loaded from the built-in table,
// all 1025 entries, with busy high; afterwards busy stays low.
// ----------------------------------------------------------------------------
module sigmoid_table_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sti_pkg::IN_W-1:0]  in_sample_in,
  output logic                             out_valid,
  output logic [sti_pkg::OUT_W-1:0]        out_sigmoid_out
);

  import sti_pkg::*;

  logic              fill_r;
  logic              fill_nxt;
  logic [ROM_AW-1:0] fill_idx_r;
  logic [ROM_AW-1:0] fill_idx_nxt;
  logic [ROM_W-1:0]  fill_data;
  scale_t            scl;
  interp_ctl_t       ictl;
  logic [ROM_AW-1:0] addr_a;
  logic [ROM_AW-1:0] addr_b;
  logic [ROM_W-1:0]  rd_a;
  logic [ROM_W-1:0]  rd_b;

  // table load after reset
  always_comb begin
    fill_nxt     = fill_r;
    fill_idx_nxt = fill_idx_r;
    if (fill_r) begin
      if (fill_idx_r == LAST_IDX) begin
        fill_nxt = 1'b0;
      end else begin
        fill_idx_nxt = fill_idx_r + 1'b1;
      end
    end
    fill_data = SAMPLE_IMG[fill_idx_r*ROM_W +: ROM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 1'b1;
      fill_idx_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      fill_idx_r <= fill_idx_nxt;
    end
  end

  assign busy = fill_r;

  sti_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .sample  (in_sample_in),
    .scl_out (scl)
  );

  always_comb begin
    addr_a = (scl.idx > LAST_IDX) ? LAST_IDX : scl.idx;
    addr_b = (addr_a < LAST_IDX) ? addr_a + 1'b1 : addr_a;

    ictl.valid  = scl.valid;
    ictl.neg    = scl.neg;
    ictl.sat_lo = scl.sat_lo;
    ictl.sat_hi = scl.sat_hi;
    ictl.fr     = scl.fr;
  end

  sti_ram #(
    .WIDTH (ROM_W),
    .DEPTH (ROM_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (fill_r),
    .wr_addr   (fill_idx_r),
    .wr_data   (fill_data),
    .rd_addr_a (addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (addr_b),
    .rd_data_b (rd_b)
  );

  sti_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ictl),
    .r0        (rd_a),
    .r1        (rd_b),
    .out_valid (out_valid),
    .out_value (out_sigmoid_out)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without accepted transaction");

  a_sat_low: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_sample_in < LIMIT_LO) |-> ##5 (out_sigmoid_out == '0))
    else $error("low saturation wrong");

  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_sample_in > LIMIT_HI) |-> ##5 (out_sigmoid_out == ONE_Q16))
    else $error("high saturation wrong");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sigmoid_out <= ONE_Q16))
    else $error("result above one");

endmodule
